// ===== hdl/bbis_pkg.sv =====
// ----------------------------------------------------------------------------
// bbis_pkg: shared types and constants of the B-spline image scaler
// Field widths, arithmetic widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bbis_pkg;

  localparam int IDX_W    = 12;
  localparam int PIX_W    = 8;
  localparam int DIM_W    = 9;
  localparam int STEP_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFGI_W   = 2;
  localparam int POS_W    = IDX_W + STEP_W;
  localparam int CMP_W    = 32;
  localparam int T_W      = 8;
  localparam int U_W      = T_W + 1;
  localparam int T2_W     = 2 * T_W;
  localparam int U2_W     = 2 * U_W - 1;
  localparam int T3_W     = 3 * T_W;
  localparam int U3_W     = 3 * T_W + 1;
  localparam int W_W      = 27;
  localparam int PROD_W   = W_W + PIX_W;
  localparam int INNER_W  = PROD_W + 2;
  localparam int LO_W     = 19;
  localparam int HI_W     = INNER_W - LO_W;
  localparam int MLO_W    = W_W + LO_W;
  localparam int MHI_W    = W_W + HI_W;
  localparam int SUM_W    = 62;
  localparam int DIV_SH   = 50;
  localparam int X_W      = SUM_W - DIV_SH;
  localparam int RECIP    = 3641;
  localparam int RECIP_W  = 12;
  localparam int RECIP_SH = 15;
  localparam int Q_W      = X_W + RECIP_W - RECIP_SH;
  localparam int SIZE_MIN = 4;
  localparam int SCALE_S  = 256;
  localparam int S3       = SCALE_S * SCALE_S * SCALE_S;
  localparam int PIX_MAX  = 255;

  typedef enum logic [CFGI_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_ROW_STEP   = 2'd2,
    CFG_COL_STEP   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       cfg_we;
    logic       load_we;
    logic       capture;
    logic       pos_en;
    logic       split_en;
    logic       w1_en;
    logic       w2_en;
    logic       issue;
    logic [3:0] tap;
    logic       div_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic sum_done;
  } stat_t;

endpackage

// ===== hdl/bbis_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbis_ctrl: sequencer of the B-spline image scaler
// Walks one compute through position, weight, fetch and divide steps.
// ----------------------------------------------------------------------------
module bbis_ctrl
  import bbis_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  mode,
  input  logic  cfg_valid,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [3:0] {
    IDLE, POS, SPLIT, W1, W2, FETCH, DRAIN, DIV, OUT
  } state_t;

  state_t     state;
  logic [3:0] tap;
  logic       acc;

  assign in_ready = (state == IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.cfg_we   = cfg_valid;
    cmd.load_we  = acc && !mode;
    cmd.capture  = acc && mode;
    cmd.pos_en   = (state == POS);
    cmd.split_en = (state == SPLIT);
    cmd.w1_en    = (state == W1);
    cmd.w2_en    = (state == W2);
    cmd.issue    = (state == FETCH);
    cmd.tap      = tap;
    cmd.div_en   = (state == DIV);
    cmd.out_load = (state == OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      tap       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (acc && mode) state <= POS;
        end
        POS:   state <= SPLIT;
        SPLIT: state <= W1;
        W1:    state <= W2;
        W2: begin
          tap   <= '0;
          state <= FETCH;
        end
        FETCH: begin
          tap <= tap + 4'd1;
          if (tap == 4'd15) state <= DRAIN;
        end
        DRAIN: begin
          if (stat.sum_done) state <= DIV;
        end
        DIV: state <= OUT;
        OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/bbis_dpath.sv =====
// ----------------------------------------------------------------------------
// bbis_dpath: datapath of the B-spline image scaler
// Frame memory, configuration, weights, multiply-accumulate and divide.
// ----------------------------------------------------------------------------
module bbis_dpath
  import bbis_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [IDX_W-1:0]  row,
  input  logic [IDX_W-1:0]  col,
  input  logic [PIX_W-1:0]  pixel,
  output logic [PIX_W-1:0]  out_pixel
);

  localparam int CAW   = $clog2(MAX_WIDTH);
  localparam int RAW   = $clog2(MAX_HEIGHT);
  localparam int SWW   = $clog2(MAX_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IPW   = POS_W - FRAC_BITS;

  // Configuration registers.
  logic [DIM_W-1:0]  src_width, src_height;
  logic [STEP_W-1:0] row_step, col_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(256);
      src_height <= DIM_W'(256);
      row_step   <= STEP_W'(65536);
      col_step   <= STEP_W'(65536);
    end else if (cmd.cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  src_width  <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[DIM_W-1:0];
        CFG_ROW_STEP:   row_step   <= cfg_data[STEP_W-1:0];
        CFG_COL_STEP:   col_step   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SWW-1:0] w_sz;
  logic [SHW-1:0] h_sz;
  logic [CAW-1:0] w_m1;
  logic [RAW-1:0] h_m1;

  always_comb begin
    if (src_width < DIM_W'(SIZE_MIN)) w_sz = SWW'(SIZE_MIN);
    else if (CMP_W'(src_width) > CMP_W'(MAX_WIDTH)) w_sz = SWW'(MAX_WIDTH);
    else w_sz = SWW'(src_width);
    if (src_height < DIM_W'(SIZE_MIN)) h_sz = SHW'(SIZE_MIN);
    else if (CMP_W'(src_height) > CMP_W'(MAX_HEIGHT)) h_sz = SHW'(MAX_HEIGHT);
    else h_sz = SHW'(src_height);
    w_m1 = CAW'(w_sz - SWW'(1));
    h_m1 = RAW'(h_sz - SHW'(1));
  end

  // Captured output index and source position.
  logic [IDX_W-1:0] idx_r, idx_c;
  logic [POS_W-1:0] pos_r, pos_c;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= row;
      idx_c <= col;
    end
    if (cmd.pos_en) begin
      pos_r <= POS_W'(idx_r) * POS_W'(row_step);
      pos_c <= POS_W'(idx_c) * POS_W'(col_step);
    end
  end

  // Integer part saturates at the last row or column; the top eight fraction bits are kept.
  logic [IPW-1:0] ip_r, ip_c;
  logic [T_W-1:0] tf_r, tf_c;
  logic [U_W-1:0] uf_r, uf_c;

  assign ip_r = pos_r[POS_W-1:FRAC_BITS];
  assign ip_c = pos_c[POS_W-1:FRAC_BITS];
  assign tf_r = pos_r[FRAC_BITS-1 -: T_W];
  assign tf_c = pos_c[FRAC_BITS-1 -: T_W];
  assign uf_r = U_W'(SCALE_S) - U_W'(tf_r);
  assign uf_c = U_W'(SCALE_S) - U_W'(tf_c);

  logic [RAW-1:0]  base_r;
  logic [CAW-1:0]  base_c;
  logic [T_W-1:0]  t_r, t_c;
  logic [U_W-1:0]  u_r, u_c;
  logic [T2_W-1:0] t2_r, t2_c;
  logic [U2_W-1:0] u2_r, u2_c;
  logic [T3_W-1:0] t3_r, t3_c;
  logic [U3_W-1:0] u3_r, u3_c;

  always_ff @(posedge clk) begin
    if (cmd.split_en) begin
      base_r <= (CMP_W'(ip_r) > CMP_W'(h_m1)) ? h_m1 : RAW'(ip_r);
      base_c <= (CMP_W'(ip_c) > CMP_W'(w_m1)) ? w_m1 : CAW'(ip_c);
      t_r    <= tf_r;
      t_c    <= tf_c;
      u_r    <= uf_r;
      u_c    <= uf_c;
      t2_r   <= T2_W'(tf_r) * T2_W'(tf_r);
      t2_c   <= T2_W'(tf_c) * T2_W'(tf_c);
      u2_r   <= U2_W'(uf_r) * U2_W'(uf_r);
      u2_c   <= U2_W'(uf_c) * U2_W'(uf_c);
    end
    if (cmd.w1_en) begin
      t3_r <= T3_W'(t2_r) * T3_W'(t_r);
      t3_c <= T3_W'(t2_c) * T3_W'(t_c);
      u3_r <= U3_W'(u2_r) * U3_W'(u_r);
      u3_c <= U3_W'(u2_c) * U3_W'(u_c);
    end
  end

  // Weights and mirrored neighbour addresses, offsets -1 to +2.
  logic [W_W-1:0] wr [4];
  logic [W_W-1:0] wc [4];
  logic [RAW-1:0] ra [4];
  logic [CAW-1:0] ca [4];

  always_ff @(posedge clk) begin
    if (cmd.w2_en) begin
      wr[0] <= W_W'(u3_r);
      wr[1] <= W_W'(4 * S3) + W_W'(3) * W_W'(t3_r) - W_W'(6) * (W_W'(t2_r) << 8);
      wr[2] <= W_W'(S3) + W_W'(3) * (W_W'(t_r) << 16) + W_W'(3) * (W_W'(t2_r) << 8)
               - W_W'(3) * W_W'(t3_r);
      wr[3] <= W_W'(t3_r);
      wc[0] <= W_W'(u3_c);
      wc[1] <= W_W'(4 * S3) + W_W'(3) * W_W'(t3_c) - W_W'(6) * (W_W'(t2_c) << 8);
      wc[2] <= W_W'(S3) + W_W'(3) * (W_W'(t_c) << 16) + W_W'(3) * (W_W'(t2_c) << 8)
               - W_W'(3) * W_W'(t3_c);
      wc[3] <= W_W'(t3_c);

      ra[0] <= (base_r == '0) ? '0 : base_r - RAW'(1);
      ra[1] <= base_r;
      ra[2] <= (base_r == h_m1) ? base_r : base_r + RAW'(1);
      if (base_r == h_m1) ra[3] <= h_m1 - RAW'(1);
      else if (base_r == h_m1 - RAW'(1)) ra[3] <= h_m1;
      else ra[3] <= base_r + RAW'(2);

      ca[0] <= (base_c == '0) ? '0 : base_c - CAW'(1);
      ca[1] <= base_c;
      ca[2] <= (base_c == w_m1) ? base_c : base_c + CAW'(1);
      if (base_c == w_m1) ca[3] <= w_m1 - CAW'(1);
      else if (base_c == w_m1 - CAW'(1)) ca[3] <= w_m1;
      else ca[3] <= base_c + CAW'(2);
    end
  end

  // Single-port frame memory.
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [AW-1:0]    waddr, raddr, addr;
  logic             in_range, we;

  assign in_range = (CMP_W'(row) < CMP_W'(MAX_HEIGHT)) && (CMP_W'(col) < CMP_W'(MAX_WIDTH));
  assign we       = cmd.load_we && in_range;
  assign waddr    = AW'(CMP_W'(row) * CMP_W'(MAX_WIDTH) + CMP_W'(col));
  assign raddr    = AW'(CMP_W'(ra[cmd.tap[3:2]]) * CMP_W'(MAX_WIDTH)
                        + CMP_W'(ca[cmd.tap[1:0]]));
  assign addr     = cmd.load_we ? waddr : raddr;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= pixel;
    rd_data <= mem[addr];
  end

  // Multiply-accumulate pipeline: read, column product, row sum, row product, total.
  logic                v1, v2, v3, v4;
  logic                last1, last2, last3, last4;
  logic [1:0]          r1, r2, r3, c1, c2;
  logic [PROD_W-1:0]   prod;
  logic [INNER_W-1:0]  inner;
  logic [MLO_W-1:0]    mlo;
  logic [MHI_W-1:0]    mhi;
  logic [SUM_W-1:0]    sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      stat.sum_done <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2 && (c2 == 2'd3);
      v4 <= v3;
      stat.sum_done <= v4 && last4;
    end
  end

  always_ff @(posedge clk) begin
    r1    <= cmd.tap[3:2];
    c1    <= cmd.tap[1:0];
    last1 <= (cmd.tap == 4'd15);
    r2    <= r1;
    c2    <= c1;
    last2 <= last1;
    prod  <= PROD_W'(wc[c1]) * PROD_W'(rd_data);
    if (v2) begin
      inner <= (c2 == 2'd0) ? INNER_W'(prod) : inner + INNER_W'(prod);
      r3    <= r2;
      last3 <= last2;
    end
    mlo   <= MLO_W'(wr[r3]) * MLO_W'(inner[LO_W-1:0]);
    mhi   <= MHI_W'(wr[r3]) * MHI_W'(inner[INNER_W-1:LO_W]);
    last4 <= last3;
    if (cmd.capture) sum <= '0;
    else if (v4) sum <= sum + SUM_W'(mlo) + (SUM_W'(mhi) << LO_W);
  end

  // Divide by 36*S^6 = 9*2^50: shift, then multiply by a reciprocal of nine.
  logic [X_W-1:0]             xq;
  logic [X_W+RECIP_W-1:0]     xm;
  logic [Q_W-1:0]             quo;

  assign xq = sum[SUM_W-1:DIV_SH];
  assign xm = (X_W+RECIP_W)'(xq) * (X_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_en) quo <= xm[X_W+RECIP_W-1:RECIP_SH];
    if (cmd.out_load) begin
      out_pixel <= (quo > Q_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : quo[PIX_W-1:0];
    end
  end

endmodule

// ===== hdl/bspline_bicubic_image_scaler_core.sv =====
// A load transfer writes one in-range pixel in the cycle it is accepted; the block is ready again next.
// A compute passes through the position, split, weight, fetch, drain and divide steps, and the block takes
// no new item until the result is in the output register, so computes do not overlap.
// The sixteen neighbourhood reads go one after another through the single frame memory port.
// Synchronous reset restores the register defaults and empties the pipeline and output;
// the frame memory is not cleared.
// ----------------------------------------------------------------------------
// bspline_bicubic_image_scaler_core: cubic B-spline image scaler
// Frame store, controller and datapath for 4x4 B-spline interpolation.
// ----------------------------------------------------------------------------
module bspline_bicubic_image_scaler_core
  import bbis_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [IDX_W-1:0]  row,
  input  logic [IDX_W-1:0]  col,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bbis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .cfg_valid (cfg_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bbis_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row       (row),
    .col       (col),
    .pixel     (pixel),
    .out_pixel (out_pixel)
  );

endmodule

// ===== hdl/bbis_checker.sv =====
// ----------------------------------------------------------------------------
// bbis_checker: port-level checks of the B-spline image scaler
// Watches handshakes and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module bbis_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("result changed while stalled");

  // A load transfer never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !mode && !out_valid |=> !out_valid)
    else $error("load produced a result");

  // A compute keeps the input side busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode |=> !in_ready)
    else $error("input taken while computing");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bspline_bicubic_image_scaler_core bbis_checker u_bbis_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pixel (out_pixel)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the cubic B-spline image scaler core
// Loads small source images, requests output pixels under several size and
// zoom settings and compares each answer against a bit-exact predictor.
// ----------------------------------------------------------------------------
class pixel_scoreboard;
  logic [7:0] frame [0:65535];
  int unsigned width_reg, height_reg, rstep_reg, cstep_reg;
  logic [7:0] expected_pixels [$];
  int mismatches;

  function new();
    width_reg = 256;
    height_reg = 256;
    rstep_reg = 65536;
    cstep_reg = 65536;
    mismatches = 0;
  endfunction

  function void set_reg(int idx, int unsigned v);
    case (idx)
      bbis_pkg::CFG_SRC_WIDTH:  width_reg = v & 'h1FF;
      bbis_pkg::CFG_SRC_HEIGHT: height_reg = v & 'h1FF;
      bbis_pkg::CFG_ROW_STEP:   rstep_reg = v & 'hFFFFF;
      default:                  cstep_reg = v & 'hFFFFF;
    endcase
  endfunction

  function int unsigned clamp_dim(int unsigned v);
    if (v < 4) return 4;
    if (v > 256) return 256;
    return v;
  endfunction

  function int mirror(int a, int size);
    if (a < 0) a = -a - 1;
    if (a >= size) a = 2 * size - 1 - a;
    if (a < 0) a = 0;
    if (a >= size) a = size - 1;
    return a;
  endfunction

  function void spline_weights(longint unsigned t, output longint unsigned w [4]);
    longint unsigned s3, u, t2, t3;
    s3 = 64'd256 * 256 * 256;
    u = 256 - t;
    t2 = t * t;
    t3 = t2 * t;
    w[0] = u * u * u;
    w[1] = (4 * s3 + 3 * t3) - 6 * 256 * t2;
    w[2] = (s3 + 3 * 256 * 256 * t + 3 * 256 * t2) - 3 * t3;
    w[3] = t3;
  endfunction

  function void note_input(logic m, logic [11:0] r, logic [11:0] c, logic [7:0] p);
    int unsigned w, h;
    longint unsigned pos, ip, rt, ct, sum, inner, res;
    longint unsigned wr [4], wc [4];
    int rb, cb, ra, ca;
    if (!m) begin
      if (r < 256 && c < 256) frame[r * 256 + c] = p;
      return;
    end
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    pos = longint'(r) * rstep_reg;
    ip = pos >> 16;
    if (ip > h - 1) ip = h - 1;
    rb = int'(ip);
    rt = (pos & 'hFFFF) >> 8;
    pos = longint'(c) * cstep_reg;
    ip = pos >> 16;
    if (ip > w - 1) ip = w - 1;
    cb = int'(ip);
    ct = (pos & 'hFFFF) >> 8;
    spline_weights(rt, wr);
    spline_weights(ct, wc);
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      ra = mirror(rb + i - 1, h);
      inner = 0;
      for (int j = 0; j < 4; j++) begin
        ca = mirror(cb + j - 1, w);
        inner += wc[j] * frame[ra * 256 + ca];
      end
      sum += wr[i] * inner;
    end
    res = sum / (64'd36 << 48);
    if (res > 255) res = 255;
    expected_pixels.push_back(res[7:0]);
  endfunction

  function void check_result(logic [7:0] got);
    logic [7:0] want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %0d", got);
      return;
    end
    want = expected_pixels.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("out_pixel mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module tb;
  import bbis_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, mode = 0, out_ready = 0, cfg_valid = 0;
  logic [11:0] row = 0, col = 0;
  logic [7:0] pixel = 0;
  logic [1:0] cfg_index = 0;
  logic [19:0] cfg_data = 0;
  wire in_ready, out_valid, cfg_ready;
  wire [7:0] out_pixel;
  pixel_scoreboard sb = new();
  int unsigned cycles = 0;
  int img_w = 256, img_h = 256;

  bspline_bicubic_image_scaler_core dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: stall pattern changes slowly, including long stall-free stretches.
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && out_valid && out_ready) sb.check_result(out_pixel);
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Valid stays high between items of one burst and drops only for a gap or a drain.
  int burst_left = 0;
  task automatic send_item(logic m, int r, int c, int p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1;
    mode <= m;
    row <= 12'(r);
    col <= 12'(c);
    pixel <= 8'(p);
    do @(posedge clk); while (!in_ready);
    sb.note_input(m, 12'(r), 12'(c), 8'(p));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 20'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Sets a geometry and fills the whole used image so no unwritten entry is read.
  task automatic set_image(int w, int h, int rs, int cs);
    drain();
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_SRC_HEIGHT, h);
    write_reg(CFG_ROW_STEP, rs);
    write_reg(CFG_COL_STEP, cs);
    img_w = sb.clamp_dim(w);
    img_h = sb.clamp_dim(h);
    for (int r = 0; r < img_h; r++)
      for (int c = 0; c < img_w; c++)
        send_item(0, r, c, $urandom_range(0, 255));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_item(0, $urandom_range(0, img_h - 1), $urandom_range(0, img_w - 1),
                     $urandom_range(0, 255));
        1: send_item(0, $urandom_range(256, 4095), $urandom, $urandom);
        2: send_item(1, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
        default: send_item(1, $urandom_range(0, 2 * img_h), $urandom_range(0, 2 * img_w),
                           $urandom);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: small image, extremes, borders, saturating sizes and steps.
    set_image(2, 3, 65536, 65536);
    send_item(1, 1, 1, 0);
    send_item(1, 9, 9, 0);
    drain();
    // Height above its maximum, with a zero row step so only the first rows are read.
    write_reg(CFG_SRC_HEIGHT, 300);
    write_reg(CFG_ROW_STEP, 0);
    send_item(1, 5, 2, 0);
    set_image(4, 4, 65536, 65536);
    send_item(0, 4095, 4095, 255);
    send_item(0, 0, 256, 255);
    send_item(1, 0, 0, 0);
    send_item(1, 3, 3, 255);
    send_item(1, 4095, 4095, 0);
    send_item(1, 1, 2, 0);
    drain();
    write_reg(CFG_ROW_STEP, 0);
    write_reg(CFG_COL_STEP, 20'hFFFFF);
    send_item(1, 7, 1, 0);
    send_item(1, 4095, 4095, 0);
    drain();
    write_reg(CFG_ROW_STEP, 1);
    write_reg(CFG_COL_STEP, 32768 + 128);
    send_item(1, 4095, 5, 0);
    send_item(1, 2, 3, 0);
    drain();
    // Random phases over several geometries.
    set_image(8, 6, 21845, 49152);
    random_phase(130);
    set_image(16, 12, 98304, 40000);
    random_phase(130);
    set_image(5, 9, $urandom_range(1, 20'hFFFFF), $urandom_range(1, 20'hFFFFF));
    random_phase(100);
    drain();
    set_image(7, 4, 12345, 70000);
    random_phase(130);
    drain();
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/bbis_pkg.sv
hdl/bbis_ctrl.sv
hdl/bbis_dpath.sv
hdl/bspline_bicubic_image_scaler_core.sv
hdl/bbis_checker.sv
bench/tb.sv
